// ----- src/bpe_pkg.sv -----
// Shared types and fixed constants for the Bezier point evaluator.
`default_nettype none
package bpe_pkg;

	// width of the points_used result field
	localparam int PU_W = 5;

	// APB data width
	localparam int APB_DW = 32;

	// register index bit (paddr[2]) of output_mode
	localparam logic REG_OUTPUT_MODE = 1'b0;

	// per-cycle command from the sequencer to every cell of the row
	typedef struct packed {
		logic diff_en;  // latch neighbor minus own value
		logic mul_en;   // scale the difference and update the point
		logic deriv;    // derivative pass: scale by degree and clip
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- src/bpe_cell.sv -----
// One cell of the De Casteljau row: holds one control point, steps it toward its neighbor.
`default_nettype none
module bpe_cell #(
	parameter int CW = 32,
	parameter int F  = 16,
	parameter int MW = 17
) (
	input  logic                    clk,
	input  bpe_pkg::cell_ctrl_t     ctrl,
	input  logic                    load,
	input  logic [2:0][CW-1:0]      ld_p,
	input  logic [2:0][CW-1:0]      nb_p,
	input  logic [MW-1:0]           mul_op,
	output logic [2:0][CW-1:0]      p,
	output logic                    clip
);

	localparam int DW = CW + 1;
	localparam int PW = DW + MW + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1 << (F - 1));

	logic [2:0] clip_c;

	genvar c;
	generate
		for (c = 0; c < 3; c++) begin : g_coord
			logic        [CW-1:0] p_q;
			logic signed [DW-1:0] d_s1;
			logic signed [PW-1:0] prod;
			logic signed [PW-1:0] rnd;
			logic        [CW-1:0] lerp_v;
			logic        [CW-1:0] der_v;
			logic                 ovf;

			// one multiplier per coordinate, shared by lerp and degree scaling
			assign prod   = d_s1 * $signed({1'b0, mul_op});
			assign rnd    = (prod + HALF) >>> F;
			// true result lies between the two points, so wrap-around add is exact
			assign lerp_v = p_q + rnd[CW-1:0];
			assign ovf    = !((&prod[PW-1:CW-1]) || !(|prod[PW-1:CW-1]));
			assign der_v  = ovf ? {prod[PW-1], {(CW-1){~prod[PW-1]}}} : prod[CW-1:0];
			assign clip_c[c] = ovf;
			assign p[c]   = p_q;

			always_ff @(posedge clk) begin
				if (load) begin
					p_q <= ld_p[c];
				end else if (ctrl.mul_en) begin
					p_q <= ctrl.deriv ? der_v : lerp_v;
				end
				if (ctrl.diff_en) begin
					d_s1 <= $signed({nb_p[c][CW-1], nb_p[c]}) - $signed({p_q[CW-1], p_q});
				end
			end
		end
	endgenerate

	assign clip = ctrl.mul_en && ctrl.deriv && (|clip_c);

endmodule
`default_nettype wire

// ----- src/bpe_ctrl.sv -----
// Pass sequencer for the cell row: difference step, multiply step, result step.
`default_nettype none
module bpe_ctrl #(
	parameter int CNT_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [CNT_W-1:0]     go_passes,
	input  logic                 go_deriv,
	output logic                 busy,
	output logic                 done,
	output bpe_pkg::cell_ctrl_t  ctrl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIFF = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] pass_q;
	logic             deriv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= '0;
			deriv_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						pass_q  <= go_passes;
						deriv_q <= go_deriv;
						state_q <= (go_passes == '0) ? ST_OUT : ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					pass_q  <= pass_q - CNT_W'(1);
					deriv_q <= 1'b0;  // only the first pass differentiates
					state_q <= (pass_q == CNT_W'(1)) ? ST_OUT : ST_DIFF;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = (state_q == ST_OUT);
	assign ctrl.diff_en = (state_q == ST_DIFF);
	assign ctrl.mul_en  = (state_q == ST_MUL);
	assign ctrl.deriv   = deriv_q;

endmodule
`default_nettype wire

// ----- src/bezier_point_evaluator_top.sv -----
// Top level of the Bezier point evaluator: point store, cell row, APB register, result port.
`default_nettype none
// Evaluates a 3-D Bezier curve (position or first derivative) by De Casteljau's scheme.
// Control points (signed Q16.16) are sent one per beat with start; a beat is taken when
// start is high and busy is low. A point beat without last_point is stored and busy
// stays low. The beat with last_point stores its point too, then raises busy while
// the row works through the n-1 reduction passes, n being the number of stored points:
// each pass is a difference step and a multiply step in the cell row, followed by a step
// that registers the result. The result shows on out_x/out_y/out_z with result_valid for
// exactly one cycle, in the same cycle that busy falls; the receiver cannot stall it, so it
// must take the beat then. A new curve may start in that same cycle.
// param_t is Q1.16 (65536 = 1.0), used only on the last beat, clamped to 1.0 above that.
// Points past MAX_POINTS are dropped and flagged in too_many_points. In derivative mode
// (output_mode = 1) the first pass forms degree * (next - this), clipped to 32 bits,
// which raises saturated; one point alone gives zero. output_mode sits at APB address 0
// and must only be written while the block is idle.
module bezier_point_evaluator_top #(
	parameter int MAX_POINTS  = 16,
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic [COORD_WIDTH-1:0]     point_x,
	input  logic [COORD_WIDTH-1:0]     point_y,
	input  logic [COORD_WIDTH-1:0]     point_z,
	input  logic [T_FRAC_BITS:0]       param_t,
	input  logic                       last_point,
	// result side
	output logic                       result_valid,
	output logic [COORD_WIDTH-1:0]     out_x,
	output logic [COORD_WIDTH-1:0]     out_y,
	output logic [COORD_WIDTH-1:0]     out_z,
	output logic [bpe_pkg::PU_W-1:0]   points_used,
	output logic                       too_many_points,
	output logic                       saturated,
	// APB configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [bpe_pkg::APB_DW-1:0] pwdata,
	output logic [bpe_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int MW    = (T_FRAC_BITS + 1 > CNT_W) ? T_FRAC_BITS + 1 : CNT_W;
	localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	// handshake
	logic acc;
	logic go;
	logic full;

	// store fill state
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             mode_q;

	// per-evaluation context, captured on the last beat
	logic [T_FRAC_BITS:0] t_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     npass_q;
	logic                 eval_ovf_q;
	logic                 eval_deriv_q;
	logic                 sat_q;

	// result registers
	logic                   result_valid_q;
	logic [COORD_WIDTH-1:0] out_x_q;
	logic [COORD_WIDTH-1:0] out_y_q;
	logic [COORD_WIDTH-1:0] out_z_q;
	logic [bpe_pkg::PU_W-1:0] points_used_q;
	logic                   too_many_q;
	logic                   saturated_q;

	// row
	bpe_pkg::cell_ctrl_t            cctrl;
	logic                           done;
	logic [CNT_W-1:0]               go_passes;
	logic [MW-1:0]                  mul_op;
	logic [2:0][COORD_WIDTH-1:0]    ld_p;
	logic [2:0][COORD_WIDTH-1:0]    cell_p [MAX_POINTS];
	logic [MAX_POINTS-1:0]          cell_clip;
	logic [MAX_POINTS-1:0]          clip_live;
	logic                           res_zero;
	logic                           cfg_wr;

	assign acc  = start && !busy;
	assign go   = acc && last_point;
	assign full = (cnt_q == CNT_W'(MAX_POINTS));
	// passes = points - 1; a dropped last point does not add one
	assign go_passes = full ? (cnt_q - CNT_W'(1)) : cnt_q;

	assign ld_p[0] = point_x;
	assign ld_p[1] = point_y;
	assign ld_p[2] = point_z;

	// derivative pass multiplies by the degree, the others by t
	assign mul_op = cctrl.deriv ? MW'(npass_q) : MW'(t_q);

	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bpe_pkg::REG_OUTPUT_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			mode_q         <= 1'b0;
			sat_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mode_q <= pwdata[0];
			end
			if (go) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (go) begin
				sat_q <= 1'b0;
			end else if (|clip_live) begin
				sat_q <= 1'b1;
			end
			result_valid_q <= done;
		end
	end

	// evaluation context and result payload
	always_ff @(posedge clk) begin
		if (go) begin
			t_q          <= (param_t > T_ONE) ? T_ONE : param_t;
			n_q          <= full ? cnt_q : (cnt_q + CNT_W'(1));
			npass_q      <= go_passes;
			eval_ovf_q   <= ovf_q || full;
			eval_deriv_q <= mode_q;
		end
		if (done) begin
			out_x_q       <= res_zero ? '0 : cell_p[0][0];
			out_y_q       <= res_zero ? '0 : cell_p[0][1];
			out_z_q       <= res_zero ? '0 : cell_p[0][2];
			points_used_q <= bpe_pkg::PU_W'(n_q);
			too_many_q    <= eval_ovf_q;
			saturated_q   <= sat_q;
		end
	end

	// derivative of a single point is zero
	assign res_zero = eval_deriv_q && (npass_q == '0);

	bpe_ctrl #(
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.go_passes (go_passes),
		.go_deriv  (mode_q),
		.busy      (busy),
		.done      (done),
		.ctrl      (cctrl)
	);

	genvar i;
	generate
		for (i = 0; i < MAX_POINTS; i++) begin : g_cell
			logic [2:0][COORD_WIDTH-1:0] nb;
			logic                        load;

			// last cell has no right neighbor; its value is never used
			if (i == MAX_POINTS - 1) begin : g_end
				assign nb = cell_p[i];
			end else begin : g_mid
				assign nb = cell_p[i+1];
			end

			assign load = acc && (cnt_q == CNT_W'(i));
			// only differences between stored points count toward saturation
			assign clip_live[i] = cell_clip[i] && (CNT_W'(i) < npass_q);

			bpe_cell #(
				.CW (COORD_WIDTH),
				.F  (T_FRAC_BITS),
				.MW (MW)
			) u_cell (
				.clk    (clk),
				.ctrl   (cctrl),
				.load   (load),
				.ld_p   (ld_p),
				.nb_p   (nb),
				.mul_op (mul_op),
				.p      (cell_p[i]),
				.clip   (cell_clip[i])
			);
		end
	endgenerate

	// APB read side
	assign pready = 1'b1;
	assign prdata = (paddr[2] == bpe_pkg::REG_OUTPUT_MODE) ?
	                bpe_pkg::APB_DW'(mode_q) : '0;

	assign result_valid    = result_valid_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign out_z           = out_z_q;
	assign points_used     = points_used_q;
	assign too_many_points = too_many_q;
	assign saturated       = saturated_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_point) |=> busy)
		else $error("last beat did not start an evaluation");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond capacity");

	a_sat_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !eval_deriv_q) |-> !saturated)
		else $error("saturation flagged in position mode");

endmodule
`default_nettype wire
